>>> rtl/rmlu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmlu_pkg: shared types for the reentrant monitor lock unit
// Command, status and micro-op codes, controller states and the
// control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rmlu_pkg;

  // Default sizing
  localparam int MaxWaitersDef = 16;
  localparam int DepthBitsDef  = 16;
  localparam int IdBitsDef     = 8;

  // Fixed port field widths
  localparam int CommandW   = 3;
  localparam int RequesterW = 8;
  localparam int StatusW    = 4;
  localparam int SubjectW   = 8;
  localparam int LevelW     = 16;

  typedef enum logic [CommandW-1:0] {
    CMD_ENTER,
    CMD_TRY_ENTER,
    CMD_EXIT,
    CMD_WAIT,
    CMD_NOTIFY,
    CMD_NOTIFY_ALL,
    CMD_GIVE_UP,
    CMD_RETIRE
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_ACQUIRED,
    ST_QUEUED,
    ST_BUSY,
    ST_LEVEL_RELEASED,
    ST_RELEASED,
    ST_WAITING,
    ST_MOVED,
    ST_GRANTED,
    ST_CANCELLED,
    ST_NOT_OWNER,
    ST_FINALIZED,
    ST_OVERFLOW,
    ST_QUEUE_FULL,
    ST_REMOVED,
    ST_NO_OP
  } status_t;

  // Datapath micro-ops; all but OP_NONE and OP_RETIRE emit one result item
  typedef enum logic [3:0] {
    OP_NONE,
    OP_NEST,
    OP_CLAIM,
    OP_ENQ,
    OP_DEC,
    OP_RELEASE,
    OP_WAIT,
    OP_MOVE_HEAD,
    OP_GRANT,
    OP_REMOVE,
    OP_WMOVE,
    OP_CANCEL_LQ,
    OP_CANCEL_WL,
    OP_RETIRE,
    OP_REPORT
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GRANT,
    S_NALL,
    S_RET_LQ,
    S_RET_WL,
    S_RET_FIN
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    dp_op_t  op;
    status_t status;      // code for OP_REPORT
    logic    lvl_own;     // OP_REPORT level: own level of requester, else zero
    logic    last;
    logic    clr_retire;  // with OP_RELEASE
    logic    take;        // input ready
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic in_fire;
    logic out_free;
    logic is_owner;
    logic held;
    logic retired;
    logic depth_max;
    logic depth_gt1;
    logic lq_empty;
    logic lq_full;
    logic wl_empty;
    logic wl_full;
    logic wl_one;
    logic lq_hit;
    logic wl_hit;
  } dp_stat_t;

endpackage

>>> rtl/rmlu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmlu_in_if: request channel
// Valid/ready channel carrying one lock request item.
// ----------------------------------------------------------------------------
interface rmlu_in_if;
  logic                           valid;
  logic                           ready;
  logic [rmlu_pkg::CommandW-1:0]   command;
  logic [rmlu_pkg::RequesterW-1:0] requester;

  modport source (output valid, output command, output requester, input ready);
  modport sink   (input valid, input command, input requester, output ready);
endinterface

>>> rtl/rmlu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmlu_out_if: result channel
// Valid/ready channel carrying one lock result item.
// ----------------------------------------------------------------------------
interface rmlu_out_if;
  logic                          valid;
  logic                          ready;
  logic [rmlu_pkg::StatusW-1:0]  status;
  logic [rmlu_pkg::SubjectW-1:0] subject_thread;
  logic [rmlu_pkg::LevelW-1:0]   hold_level;
  logic                          last;

  modport source (output valid, output status, output subject_thread,
                  output hold_level, output last, input ready);
  modport sink   (input valid, input status, input subject_thread,
                  input hold_level, input last, output ready);
endinterface

>>> rtl/rmlu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmlu_ctrl: request sequencer
// Decodes the latched request against lock status and issues at most one
// datapath micro-op per step, walking queues for notify-all and retire.
// ----------------------------------------------------------------------------
module rmlu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  rmlu_pkg::dp_stat_t stat,
  output rmlu_pkg::ctl_cmd_t ctl
);

  rmlu_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmlu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rmlu_pkg::S_IDLE: begin
        if (stat.in_fire) state_next = rmlu_pkg::S_EXEC;
      end
      rmlu_pkg::S_EXEC: begin
        if (stat.out_free) begin
          state_next = rmlu_pkg::S_IDLE;
          case (stat.cmd)
            rmlu_pkg::CMD_EXIT: begin
              if (stat.is_owner && !stat.depth_gt1 && !stat.lq_empty)
                state_next = rmlu_pkg::S_GRANT;
            end
            rmlu_pkg::CMD_WAIT: begin
              if (stat.is_owner && !stat.wl_full && !stat.lq_empty)
                state_next = rmlu_pkg::S_GRANT;
            end
            rmlu_pkg::CMD_NOTIFY_ALL: begin
              if (stat.is_owner && !stat.wl_empty) state_next = rmlu_pkg::S_NALL;
            end
            rmlu_pkg::CMD_GIVE_UP: begin
              if (!stat.lq_hit && stat.wl_hit && !stat.lq_full && !stat.held)
                state_next = rmlu_pkg::S_GRANT;
            end
            rmlu_pkg::CMD_RETIRE: begin
              if (!stat.retired && (stat.held || !stat.lq_empty || !stat.wl_empty))
                state_next = rmlu_pkg::S_RET_LQ;
            end
            default: state_next = rmlu_pkg::S_IDLE;
          endcase
        end
      end
      rmlu_pkg::S_GRANT: begin
        if (stat.out_free) state_next = rmlu_pkg::S_IDLE;
      end
      rmlu_pkg::S_NALL: begin
        if (stat.out_free && (stat.lq_full || stat.wl_one)) state_next = rmlu_pkg::S_IDLE;
      end
      rmlu_pkg::S_RET_LQ: begin
        if (stat.out_free && stat.lq_empty) state_next = rmlu_pkg::S_RET_WL;
      end
      rmlu_pkg::S_RET_WL: begin
        if (stat.out_free && stat.wl_empty) state_next = rmlu_pkg::S_RET_FIN;
      end
      rmlu_pkg::S_RET_FIN: begin
        if (stat.out_free) state_next = rmlu_pkg::S_IDLE;
      end
      default: state_next = rmlu_pkg::S_IDLE;
    endcase
  end

  // Micro-op issue; every op waits for a free output slot
  always_comb begin
    ctl            = '0;
    ctl.op         = rmlu_pkg::OP_NONE;
    ctl.status     = rmlu_pkg::ST_NO_OP;
    ctl.lvl_own    = 1'b1;
    ctl.last       = 1'b1;
    ctl.take       = (state == rmlu_pkg::S_IDLE);
    case (state)
      rmlu_pkg::S_EXEC: begin
        if (stat.out_free) begin
          case (stat.cmd)
            rmlu_pkg::CMD_ENTER, rmlu_pkg::CMD_TRY_ENTER: begin
              if (stat.retired) begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_FINALIZED;
              end else if (stat.is_owner) begin
                if (stat.depth_max) begin
                  ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_OVERFLOW;
                end else begin
                  ctl.op = rmlu_pkg::OP_NEST;
                end
              end else if (!stat.held && stat.lq_empty) begin
                ctl.op = rmlu_pkg::OP_CLAIM;
              end else if (stat.cmd == rmlu_pkg::CMD_TRY_ENTER) begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_BUSY;
              end else if (stat.lq_full) begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_QUEUE_FULL;
              end else begin
                ctl.op = rmlu_pkg::OP_ENQ;
              end
            end
            rmlu_pkg::CMD_EXIT: begin
              if (!stat.is_owner) begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_NOT_OWNER;
              end else if (stat.depth_gt1) begin
                ctl.op = rmlu_pkg::OP_DEC;
              end else begin
                ctl.op         = rmlu_pkg::OP_RELEASE;
                ctl.last       = stat.lq_empty;
                ctl.clr_retire = stat.retired && stat.lq_empty && stat.wl_empty;
              end
            end
            rmlu_pkg::CMD_WAIT: begin
              if (!stat.is_owner) begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_NOT_OWNER;
              end else if (stat.wl_full) begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_QUEUE_FULL;
              end else begin
                ctl.op   = rmlu_pkg::OP_WAIT;
                ctl.last = stat.lq_empty;
              end
            end
            rmlu_pkg::CMD_NOTIFY, rmlu_pkg::CMD_NOTIFY_ALL: begin
              if (!stat.is_owner) begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_NOT_OWNER;
              end else if (stat.wl_empty) begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_NO_OP;
              end else if (stat.cmd == rmlu_pkg::CMD_NOTIFY) begin
                if (stat.lq_full) begin
                  ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_QUEUE_FULL;
                end else begin
                  ctl.op = rmlu_pkg::OP_MOVE_HEAD;
                end
              end
              // notify-all continues in its own walk state
            end
            rmlu_pkg::CMD_GIVE_UP: begin
              if (stat.lq_hit) begin
                ctl.op = rmlu_pkg::OP_REMOVE;
              end else if (stat.wl_hit) begin
                if (stat.lq_full) begin
                  ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_QUEUE_FULL;
                  ctl.lvl_own = 1'b0;
                end else begin
                  ctl.op   = rmlu_pkg::OP_WMOVE;
                  ctl.last = stat.held;
                end
              end else begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_NO_OP;
              end
            end
            rmlu_pkg::CMD_RETIRE: begin
              if (stat.retired) begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_NO_OP;
              end else if (stat.held || !stat.lq_empty || !stat.wl_empty) begin
                ctl.op = rmlu_pkg::OP_RETIRE;
              end else begin
                ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_FINALIZED;
                ctl.lvl_own = 1'b0;
              end
            end
            default: ctl.op = rmlu_pkg::OP_NONE;
          endcase
        end
      end
      rmlu_pkg::S_GRANT: begin
        if (stat.out_free) ctl.op = rmlu_pkg::OP_GRANT;
      end
      rmlu_pkg::S_NALL: begin
        if (stat.out_free) begin
          if (stat.lq_full) begin
            ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_QUEUE_FULL;
          end else begin
            ctl.op   = rmlu_pkg::OP_MOVE_HEAD;
            ctl.last = stat.wl_one;
          end
        end
      end
      rmlu_pkg::S_RET_LQ: begin
        if (stat.out_free && !stat.lq_empty) begin
          ctl.op = rmlu_pkg::OP_CANCEL_LQ; ctl.last = 1'b0;
        end
      end
      rmlu_pkg::S_RET_WL: begin
        if (stat.out_free && !stat.wl_empty) begin
          ctl.op = rmlu_pkg::OP_CANCEL_WL; ctl.last = 1'b0;
        end
      end
      rmlu_pkg::S_RET_FIN: begin
        if (stat.out_free) begin
          ctl.op = rmlu_pkg::OP_REPORT; ctl.status = rmlu_pkg::ST_FINALIZED;
        end
      end
      default: ctl.op = rmlu_pkg::OP_NONE;
    endcase
  end

  // A hand-off only starts with the lock free and someone queued
  a_grant_ready: assert property (@(posedge clk) disable iff (rst)
    (state == rmlu_pkg::S_GRANT) |-> (!stat.held && !stat.lq_empty))
    else $error("grant step without a free lock and a queued thread");

endmodule

>>> rtl/rmlu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmlu_dp: lock state, queues and result register
// Holds owner, depth, retired flag and two shift queues; executes one
// micro-op per cycle while the output slot is free and loads the result register.
// ----------------------------------------------------------------------------
module rmlu_dp #(
  parameter int MaxWaiters = rmlu_pkg::MaxWaitersDef,
  parameter int DepthBits  = rmlu_pkg::DepthBitsDef,
  parameter int IdBits     = rmlu_pkg::IdBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  rmlu_in_if.sink            in_ch,
  rmlu_out_if.source         out_ch,
  input  rmlu_pkg::ctl_cmd_t ctl,
  output rmlu_pkg::dp_stat_t stat
);

  localparam int CntW = $clog2(MaxWaiters + 1);
  localparam int IdxW = $clog2(MaxWaiters);

  // Latched request
  rmlu_pkg::cmd_t    cmd_q;
  logic [IdBits-1:0] req_q;

  // Lock state
  logic [IdBits-1:0]    owner_thread;
  logic                 owner_held;
  logic [DepthBits-1:0] hold_depth;
  logic                 retired_flag;

  // Queues: entry 0 is the head, shifting toward it on removal
  logic [IdBits-1:0]    lq_thr [MaxWaiters];
  logic [DepthBits-1:0] lq_dep [MaxWaiters];
  logic [CntW-1:0]      lq_count;
  logic [IdBits-1:0]    wl_thr [MaxWaiters];
  logic [DepthBits-1:0] wl_dep [MaxWaiters];
  logic [CntW-1:0]      wl_count;

  // Result register
  logic                          out_valid;
  rmlu_pkg::status_t             out_status;
  logic [rmlu_pkg::SubjectW-1:0] out_subject;
  logic [rmlu_pkg::LevelW-1:0]   out_level;
  logic                          out_last;

  logic                       in_fire, out_free, is_owner;
  logic [IdBits+rmlu_pkg::RequesterW-1:0] req_wide;
  logic [DepthBits-1:0]       own_lvl;
  logic [MaxWaiters-1:0]      lq_hitv, wl_hitv;
  logic [IdxW-1:0]            lq_idx, wl_idx;

  logic                 lq_rm, lq_push, wl_rm, wl_push;
  logic [IdxW-1:0]      lq_rm_idx, wl_rm_idx;
  logic [IdBits-1:0]    lq_push_thr, wl_push_thr;
  logic [DepthBits-1:0] lq_push_dep, wl_push_dep;

  logic                 e_valid;
  rmlu_pkg::status_t    e_status;
  logic [IdBits-1:0]    e_thr;
  logic [DepthBits-1:0] e_lvl;
  logic [IdBits+rmlu_pkg::SubjectW-1:0]  e_thr_wide;
  logic [DepthBits+rmlu_pkg::LevelW-1:0] e_lvl_wide;

  // Handshakes
  assign in_fire      = in_ch.valid && ctl.take;
  assign in_ch.ready  = ctl.take;
  assign out_free     = !out_valid || out_ch.ready;
  assign req_wide     = {{IdBits{1'b0}}, in_ch.requester};

  assign is_owner = owner_held && (owner_thread == req_q);
  assign own_lvl  = is_owner ? hold_depth : '0;

  // First matching queue entry for give-up
  always_comb begin
    lq_idx = '0;
    wl_idx = '0;
    for (int k = 0; k < MaxWaiters; k++) begin
      lq_hitv[k] = (CntW'(k) < lq_count) && (lq_thr[k] == req_q);
      wl_hitv[k] = (CntW'(k) < wl_count) && (wl_thr[k] == req_q);
    end
    for (int k = MaxWaiters - 1; k >= 0; k--) begin
      if (lq_hitv[k]) lq_idx = IdxW'(k);
      if (wl_hitv[k]) wl_idx = IdxW'(k);
    end
  end

  // Status toward the controller
  always_comb begin
    stat           = '0;
    stat.cmd       = cmd_q;
    stat.in_fire   = in_fire;
    stat.out_free  = out_free;
    stat.is_owner  = is_owner;
    stat.held      = owner_held;
    stat.retired   = retired_flag;
    stat.depth_max = (hold_depth == {DepthBits{1'b1}});
    stat.depth_gt1 = (hold_depth > DepthBits'(1));
    stat.lq_empty  = (lq_count == '0);
    stat.lq_full   = (lq_count == CntW'(MaxWaiters));
    stat.wl_empty  = (wl_count == '0);
    stat.wl_full   = (wl_count == CntW'(MaxWaiters));
    stat.wl_one    = (wl_count == CntW'(1));
    stat.lq_hit    = |lq_hitv;
    stat.wl_hit    = |wl_hitv;
  end

  // Queue moves and the emitted result per micro-op
  always_comb begin
    lq_rm = 1'b0; lq_rm_idx = '0; lq_push = 1'b0;
    lq_push_thr = req_q; lq_push_dep = DepthBits'(1);
    wl_rm = 1'b0; wl_rm_idx = '0; wl_push = 1'b0;
    wl_push_thr = req_q; wl_push_dep = hold_depth;
    e_valid  = 1'b1;
    e_status = rmlu_pkg::ST_NO_OP;
    e_thr    = req_q;
    e_lvl    = '0;
    case (ctl.op)
      rmlu_pkg::OP_NEST: begin
        e_status = rmlu_pkg::ST_ACQUIRED; e_lvl = hold_depth + DepthBits'(1);
      end
      rmlu_pkg::OP_CLAIM: begin
        e_status = rmlu_pkg::ST_ACQUIRED; e_lvl = DepthBits'(1);
      end
      rmlu_pkg::OP_ENQ: begin
        lq_push = 1'b1; e_status = rmlu_pkg::ST_QUEUED;
      end
      rmlu_pkg::OP_DEC: begin
        e_status = rmlu_pkg::ST_LEVEL_RELEASED; e_lvl = hold_depth - DepthBits'(1);
      end
      rmlu_pkg::OP_RELEASE: e_status = rmlu_pkg::ST_RELEASED;
      rmlu_pkg::OP_WAIT: begin
        wl_push = 1'b1; e_status = rmlu_pkg::ST_WAITING;
      end
      rmlu_pkg::OP_MOVE_HEAD: begin
        wl_rm = 1'b1; lq_push = 1'b1;
        lq_push_thr = wl_thr[0]; lq_push_dep = wl_dep[0];
        e_status = rmlu_pkg::ST_MOVED; e_thr = wl_thr[0];
      end
      rmlu_pkg::OP_GRANT: begin
        lq_rm = 1'b1;
        e_status = rmlu_pkg::ST_GRANTED; e_thr = lq_thr[0]; e_lvl = lq_dep[0];
      end
      rmlu_pkg::OP_REMOVE: begin
        lq_rm = 1'b1; lq_rm_idx = lq_idx; e_status = rmlu_pkg::ST_REMOVED;
      end
      rmlu_pkg::OP_WMOVE: begin
        wl_rm = 1'b1; wl_rm_idx = wl_idx; lq_push = 1'b1;
        lq_push_dep = wl_dep[wl_idx];
        e_status = rmlu_pkg::ST_MOVED;
      end
      rmlu_pkg::OP_CANCEL_LQ: begin
        lq_rm = 1'b1; e_status = rmlu_pkg::ST_CANCELLED; e_thr = lq_thr[0];
      end
      rmlu_pkg::OP_CANCEL_WL: begin
        wl_rm = 1'b1; e_status = rmlu_pkg::ST_CANCELLED; e_thr = wl_thr[0];
      end
      rmlu_pkg::OP_REPORT: begin
        e_status = ctl.status; e_lvl = ctl.lvl_own ? own_lvl : '0;
      end
      default: e_valid = 1'b0;
    endcase
  end

  assign e_thr_wide = {{rmlu_pkg::SubjectW{1'b0}}, e_thr};
  assign e_lvl_wide = {{rmlu_pkg::LevelW{1'b0}}, e_lvl};

  // Request latch
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q <= rmlu_pkg::cmd_t'(in_ch.command);
      req_q <= req_wide[IdBits-1:0];
    end
  end

  // Owner, depth and retired flag
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_thread <= '0;
      owner_held   <= 1'b0;
      hold_depth   <= '0;
      retired_flag <= 1'b0;
    end else begin
      case (ctl.op)
        rmlu_pkg::OP_NEST: hold_depth <= hold_depth + DepthBits'(1);
        rmlu_pkg::OP_DEC:  hold_depth <= hold_depth - DepthBits'(1);
        rmlu_pkg::OP_CLAIM: begin
          owner_thread <= req_q; owner_held <= 1'b1; hold_depth <= DepthBits'(1);
        end
        rmlu_pkg::OP_RELEASE: begin
          owner_held <= 1'b0; hold_depth <= '0;
          if (ctl.clr_retire) retired_flag <= 1'b0;
        end
        rmlu_pkg::OP_WAIT: begin
          owner_held <= 1'b0; hold_depth <= '0;
        end
        rmlu_pkg::OP_GRANT: begin
          owner_thread <= lq_thr[0]; hold_depth <= lq_dep[0]; owner_held <= 1'b1;
        end
        rmlu_pkg::OP_RETIRE: retired_flag <= 1'b1;
        default: ;
      endcase
    end
  end

  // Queue counts
  always_ff @(posedge clk) begin
    if (rst) begin
      lq_count <= '0;
      wl_count <= '0;
    end else begin
      lq_count <= lq_count + CntW'(lq_push) - CntW'(lq_rm);
      wl_count <= wl_count + CntW'(wl_push) - CntW'(wl_rm);
    end
  end

  // Queue entries: shift toward head on removal, write at tail on push
  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxWaiters - 1; k++) begin
      if (lq_rm && (IdxW'(k) >= lq_rm_idx)) begin
        lq_thr[k] <= lq_thr[k+1];
        lq_dep[k] <= lq_dep[k+1];
      end
      if (wl_rm && (IdxW'(k) >= wl_rm_idx)) begin
        wl_thr[k] <= wl_thr[k+1];
        wl_dep[k] <= wl_dep[k+1];
      end
    end
    for (int k = 0; k < MaxWaiters; k++) begin
      if (lq_push && (lq_count[IdxW-1:0] == IdxW'(k))) begin
        lq_thr[k] <= lq_push_thr;
        lq_dep[k] <= lq_push_dep;
      end
      if (wl_push && (wl_count[IdxW-1:0] == IdxW'(k))) begin
        wl_thr[k] <= wl_push_thr;
        wl_dep[k] <= wl_push_dep;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_valid) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_valid) begin
      out_status  <= e_status;
      out_subject <= e_thr_wide[rmlu_pkg::SubjectW-1:0];
      out_level   <= e_lvl_wide[rmlu_pkg::LevelW-1:0];
      out_last    <= ctl.last;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.subject_thread = out_subject;
  assign out_ch.hold_level     = out_level;
  assign out_ch.last           = out_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (lq_count <= CntW'(MaxWaiters)) && (wl_count <= CntW'(MaxWaiters)))
    else $error("queue count beyond capacity");

  a_held_depth: assert property (@(posedge clk) disable iff (rst)
    owner_held |-> (hold_depth != '0))
    else $error("lock held at depth zero");

  a_free_depth: assert property (@(posedge clk) disable iff (rst)
    !owner_held |-> (hold_depth == '0))
    else $error("free lock with nonzero depth");

endmodule

>>> rtl/reentrant_monitor_lock_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reentrant_monitor_lock_unit: reentrant monitor lock with FIFO queues
// Top level joining the request sequencer and the lock datapath.
// ----------------------------------------------------------------------------
// One request is taken at a time; input ready is high only while the unit is
// idle. A taken request emits its result items one step at a time: a release,
// wait or give-up that hands the lock on adds a granted item; notify-all emits
// one moved item per waiter moved, ending with a queue-full item when the
// acquisition queue fills first; retire on a busy lock emits one cancelled
// item per queue entry, with one step to finish each queue walk, then a
// finalized item. Each step waits while the result register is full. Queues
// are undefined after reset but only entries below their counts are ever
// read, so no clearing pass.
module reentrant_monitor_lock_unit #(
  parameter int MAX_WAITERS = rmlu_pkg::MaxWaitersDef,
  parameter int DEPTH_BITS  = rmlu_pkg::DepthBitsDef,
  parameter int ID_BITS     = rmlu_pkg::IdBitsDef
) (
  input  logic       clk,
  input  logic       rst,
  rmlu_in_if.sink    in_ch,
  rmlu_out_if.source out_ch
);

  rmlu_pkg::ctl_cmd_t ctl;
  rmlu_pkg::dp_stat_t stat;

  rmlu_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  rmlu_dp #(
    .MaxWaiters (MAX_WAITERS),
    .DepthBits  (DEPTH_BITS),
    .IdBits     (ID_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctl    (ctl),
    .stat   (stat)
  );

endmodule
